// File: design/chfm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chfm_pkg
// shared codes and tables of the compass heading block
// ----------------------------------------------------------------------------
package chfm_pkg;

  localparam int CfgIndexWidth = 3;
  localparam int RegWidth      = 16;
  localparam int AtanEntries   = 24;

  typedef logic [CfgIndexWidth-1:0] cfg_index_t;

  localparam cfg_index_t RegXMinimum   = 3'd0;
  localparam cfg_index_t RegYMinimum   = 3'd1;
  localparam cfg_index_t RegXSpan      = 3'd2;
  localparam cfg_index_t RegYSpan      = 3'd3;
  localparam cfg_index_t RegDeclination = 3'd4;

  // atan(2^-i) as a 32-bit binary angle, one turn = 2^32
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2F9;
      5'd15: r = 32'h0000517C;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A2F;
      5'd19: r = 32'h00000517;
      5'd20: r = 32'h0000028B;
      5'd21: r = 32'h00000145;
      5'd22: r = 32'h000000A2;
      5'd23: r = 32'h00000051;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

// File: design/compass_heading_from_magnetometer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compass_heading_from_magnetometer
// calibrated x/y magnetometer sample to compass heading in whole degrees
// ----------------------------------------------------------------------------
// usage:
//   input channel: raw_x, raw_y with in_valid / in_ready; one sample per
//   transfer. output channel: heading_degrees (0..360) with out_valid /
//   out_ready; one heading per sample, in sample order.
//   configuration: cfg_write_enable, cfg_index, cfg_data; write only while
//   no sample is in flight. a span written as zero is stored as one.
// throughput: one sample per cycle unless the output stalls. the pipeline is a
//   chain of register stages: an input stage, 16 + FRACTION_BITS restoring
//   divider stages (one quotient bit each, both axes in parallel), a
//   saturation stage, a quadrant stage, min(CORDIC_STEPS, 24) cordic stages,
//   a declination/wrap stage and the output register.
// stall: the whole pipeline holds while out_valid is high and out_ready is
//   low; in_ready then drops. nothing is lost or repeated.
// reset: rst (synchronous) empties the pipeline and loads the calibration
//   defaults: minimums and declination zero, spans one.
// ----------------------------------------------------------------------------
module compass_heading_from_magnetometer #(
  parameter int CORDIC_STEPS  = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [15:0]        raw_x,
  input  logic signed [15:0]        raw_y,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [8:0]                heading_degrees,
  input  logic                      cfg_write_enable,
  input  chfm_pkg::cfg_index_t      cfg_index,
  input  logic [chfm_pkg::RegWidth-1:0] cfg_data
);
  import chfm_pkg::*;

  localparam int F   = FRACTION_BITS;
  localparam int Q   = 16 + F;                       // quotient bits
  localparam int N   = (CORDIC_STEPS < AtanEntries) ? CORDIC_STEPS : AtanEntries;
  localparam int NW  = F + 2;                        // normalized width
  localparam int W   = F + 4;                        // cordic datapath width
  localparam int T   = Q + N + 5;                    // stage count
  localparam int SN  = Q + 1;                        // saturation stage
  localparam int SP  = Q + 2;                        // quadrant stage

  // calibration registers
  logic signed [15:0] x_min, y_min, decl;
  logic        [15:0] x_span, y_span;
  logic        [15:0] span_wr;

  assign span_wr = (cfg_data == 16'd0) ? 16'd1 : cfg_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_min  <= '0;
      y_min  <= '0;
      x_span <= 16'd1;
      y_span <= 16'd1;
      decl   <= '0;
    end else if (cfg_write_enable) begin
      case (cfg_index)
        RegXMinimum:    x_min  <= cfg_data;
        RegYMinimum:    y_min  <= cfg_data;
        RegXSpan:       x_span <= span_wr;
        RegYSpan:       y_span <= span_wr;
        RegDeclination: decl   <= cfg_data;
        default: ;
      endcase
    end
  end

  // global advance: every stage moves when the output register is empty or out_ready is high
  logic         adv;
  logic [T-1:0] vld;

  assign adv      = !vld[T-1] || out_ready;
  assign in_ready = adv;
  assign out_valid = vld[T-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[T-2:0], in_valid};
    end
  end

  // input stage: offset and magnitude of each axis
  logic signed [16:0] dx, dy;
  assign dx = 17'(raw_x) - 17'(x_min);
  assign dy = 17'(raw_y) - 17'(y_min);

  logic [15:0]  mag_x [0:Q];
  logic [15:0]  mag_y [0:Q];
  logic [15:0]  rem_x [0:Q];
  logic [15:0]  rem_y [0:Q];
  logic [Q-1:0] quo_x [0:Q];
  logic [Q-1:0] quo_y [0:Q];
  logic         neg_x [0:Q];
  logic         neg_y [0:Q];

  always_ff @(posedge clk) begin
    if (adv) begin
      mag_x[0] <= dx[16] ? 16'(-dx) : dx[15:0];
      mag_y[0] <= dy[16] ? 16'(-dy) : dy[15:0];
      neg_x[0] <= dx[16];
      neg_y[0] <= dy[16];
      rem_x[0] <= '0;
      rem_y[0] <= '0;
      quo_x[0] <= '0;
      quo_y[0] <= '0;
    end
  end

  // restoring divider, one quotient bit per stage; zero bits follow the magnitude
  for (genvar k = 0; k < Q; k++) begin : g_div
    logic [16:0] trial_x, trial_y;
    logic        ge_x, ge_y;
    assign trial_x = {rem_x[k], mag_x[k][15]};
    assign trial_y = {rem_y[k], mag_y[k][15]};
    assign ge_x    = trial_x >= {1'b0, x_span};
    assign ge_y    = trial_y >= {1'b0, y_span};
    always_ff @(posedge clk) begin
      if (adv) begin
        mag_x[k+1] <= {mag_x[k][14:0], 1'b0};
        mag_y[k+1] <= {mag_y[k][14:0], 1'b0};
        rem_x[k+1] <= ge_x ? 16'(trial_x - {1'b0, x_span}) : trial_x[15:0];
        rem_y[k+1] <= ge_y ? 16'(trial_y - {1'b0, y_span}) : trial_y[15:0];
        quo_x[k+1] <= {quo_x[k][Q-2:0], ge_x};
        quo_y[k+1] <= {quo_y[k][Q-2:0], ge_y};
        neg_x[k+1] <= neg_x[k];
        neg_y[k+1] <= neg_y[k];
      end
    end
  end

  // saturation stage: sign, minus one half, clamp to q2.f
  function automatic logic signed [NW-1:0] sat_norm(input logic [Q-1:0] qm,
                                                    input logic neg);
    logic signed [Q+1:0] qs;
    logic signed [Q+1:0] lim;
    logic signed [NW-1:0] r;
    lim = (Q+2)'(1) <<< (F + 1);
    qs  = neg ? -$signed({2'b00, qm}) : $signed({2'b00, qm});
    qs  = qs - ((Q+2)'(1) <<< (F - 1));
    if (qs > lim - 1)
      r = NW'(lim - 1);
    else if (qs < -lim)
      r = NW'(-lim);
    else
      r = NW'(qs);
    return r;
  endfunction

  logic signed [NW-1:0] nx, ny;

  always_ff @(posedge clk) begin
    if (adv) begin
      nx <= sat_norm(quo_x[Q], neg_x[Q]);
      ny <= sat_norm(quo_y[Q], neg_y[Q]);
    end
  end

  // quadrant stage: rotate the left half plane by +-90 degrees
  logic signed [W-1:0] cx  [0:N];
  logic signed [W-1:0] cy  [0:N];
  logic        [31:0]  acc [0:N];
  logic                zro [0:N];
  logic signed [W-1:0] nxw, nyw;

  assign nxw = W'(nx);
  assign nyw = W'(ny);

  always_ff @(posedge clk) begin
    if (adv) begin
      zro[0] <= (nx == '0) && (ny == '0);
      if (nx < 0) begin
        if (ny >= 0) begin
          cx[0]  <= nyw;
          cy[0]  <= -nxw;
          acc[0] <= 32'h40000000;
        end else begin
          cx[0]  <= -nyw;
          cy[0]  <= nxw;
          acc[0] <= 32'hC0000000;
        end
      end else begin
        cx[0]  <= nxw;
        cy[0]  <= nyw;
        acc[0] <= '0;
      end
    end
  end

  // vectoring cordic, one micro-rotation per stage
  for (genvar i = 0; i < N; i++) begin : g_cordic
    logic signed [W-1:0] xs, ys;
    logic [31:0]         ang;
    assign xs  = cx[i] >>> i;
    assign ys  = cy[i] >>> i;
    assign ang = atan_turn(5'(i));
    always_ff @(posedge clk) begin
      if (adv) begin
        zro[i+1] <= zro[i];
        if (cy[i] >= 0) begin
          cx[i+1]  <= cx[i] + ys;
          cy[i+1]  <= cy[i] - xs;
          acc[i+1] <= acc[i] + ang;
        end else begin
          cx[i+1]  <= cx[i] - ys;
          cy[i+1]  <= cy[i] + xs;
          acc[i+1] <= acc[i] - ang;
        end
      end
    end
  end

  // declination stage: round to 16 bits, add, wrap once into one turn
  logic [31:0]        acc_rnd;
  logic signed [16:0] sum;
  logic [15:0]        turn;

  assign acc_rnd = zro[N] ? 32'h0000_8000 : acc[N] + 32'h0000_8000;
  assign sum     = 17'($signed(acc_rnd[31:16])) + 17'(decl);

  always_ff @(posedge clk) begin
    if (adv) begin
      // adding one turn to a negative sum leaves the low 16 bits as they are
      turn <= sum[15:0];
    end
  end

  // output stage: binary angle to degrees, rounded to nearest
  logic [24:0] deg_prod;
  assign deg_prod = 25'(turn) * 25'd360 + 25'd32768;

  always_ff @(posedge clk) begin
    if (adv) begin
      heading_degrees <= deg_prod[24:16];
    end
  end

`ifndef SYNTHESIS
  // a heading never exceeds a full circle
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> heading_degrees <= 9'd360)
    else $error("heading out of range");

  // a stalled output holds its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(heading_degrees))
    else $error("stalled heading changed");

  // the pipeline always takes a sample when the output register is empty
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // a stalled pipeline keeps its occupancy
  a_occ: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld))
    else $error("stage valid bits moved during stall");
`endif

endmodule
